// File: rtl/shie_pkg.sv
// Package for the string hash index engine.
// Holds field widths, hash mode codes, register indexes and reset values.
// No dependencies.
package shie_pkg;

    localparam int KEY_W    = 7;
    localparam int HASH_W   = 64;
    localparam int SLOT_W   = 16;
    localparam int MODE_W   = 2;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 16;
    localparam int REM_CNT_W = $clog2(HASH_W);

    typedef logic [MODE_W-1:0]    mode_t;
    typedef logic [HASH_W-1:0]    hash_t;
    typedef logic [SLOT_W-1:0]    slot_t;
    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    // hash modes; the unused code hashes as the polynomial mode
    localparam mode_t MODE_POLY = 2'd0;
    localparam mode_t MODE_FOLD = 2'd1;
    localparam mode_t MODE_DJB  = 2'd2;

    // configuration register indexes
    localparam cfg_idx_t CFG_HASH_MODE     = 1'b0;
    localparam cfg_idx_t CFG_INDEX_MODULUS = 1'b1;

    localparam mode_t HASH_MODE_RST     = MODE_POLY;
    localparam slot_t INDEX_MODULUS_RST = 16'd100;

    localparam hash_t DJB_SEED = 64'd5381;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_MOD  = 3'b010,
        ST_HOLD = 3'b100
    } state_t;

endpackage

// File: rtl/shie_byte_unit.sv
// Per-byte hash update: polynomial x31, djb2 x33 and chunked xor fold.
// Depends on shie_pkg. Purely combinational; state lives in the top level.
module shie_byte_unit
    import shie_pkg::*;
#(
    parameter int FOLD_CHUNK_BYTES = 3,
    parameter int CHUNK_W = 8 * FOLD_CHUNK_BYTES,
    parameter int FILL_W  = $clog2(FOLD_CHUNK_BYTES + 1)
) (
    input  mode_t              hash_mode,
    input  logic [KEY_W-1:0]   key_byte,
    input  logic               last_byte,
    input  logic               at_key_start,
    input  hash_t              hash_in,
    input  logic [CHUNK_W-1:0] chunk_in,
    input  logic [FILL_W-1:0]  fill_in,
    output hash_t              hash_out,
    output logic [CHUNK_W-1:0] chunk_out,
    output logic [FILL_W-1:0]  fill_out
);

    hash_t              hash_base;
    logic [CHUNK_W-1:0] chunk_base;
    logic [FILL_W-1:0]  fill_base;
    logic [CHUNK_W-1:0] chunk_shift;
    logic [FILL_W-1:0]  fill_inc;
    hash_t              byte_ext;

    always_comb begin
        // a new key starts from the seed of the current mode
        if (at_key_start) begin
            hash_base  = (hash_mode == MODE_DJB) ? DJB_SEED : '0;
            chunk_base = '0;
            fill_base  = '0;
        end else begin
            hash_base  = hash_in;
            chunk_base = chunk_in;
            fill_base  = fill_in;
        end

        byte_ext    = HASH_W'(key_byte);
        chunk_shift = (chunk_base << 8) | CHUNK_W'(key_byte);
        fill_inc    = fill_base + FILL_W'(1);

        hash_out  = hash_base;
        chunk_out = chunk_base;
        fill_out  = fill_base;

        case (hash_mode)
            MODE_FOLD: begin
                // full chunk, or a partial one closing the key, goes into the hash
                if (fill_inc >= FILL_W'(FOLD_CHUNK_BYTES) || last_byte) begin
                    hash_out  = hash_base ^ HASH_W'(chunk_shift);
                    chunk_out = '0;
                    fill_out  = '0;
                end else begin
                    chunk_out = chunk_shift;
                    fill_out  = fill_inc;
                end
            end
            MODE_DJB: begin
                hash_out = (hash_base << 5) + hash_base + byte_ext;
            end
            default: begin
                hash_out = (hash_base << 5) - hash_base + byte_ext;
            end
        endcase
    end

endmodule

// File: rtl/shie_mod_unit.sv
// Iterative 64-bit by 16-bit remainder: restoring shift-subtract, one bit a cycle.
// Depends on shie_pkg. Start pulse loads the dividend, done pulses after 64 steps.
module shie_mod_unit
    import shie_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  start,
    input  hash_t dividend,
    input  slot_t modulus,
    output logic  done,
    output slot_t remainder
);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [REM_CNT_W-1:0] cnt_reg, cnt_next;
    hash_t                div_reg, div_next;
    slot_t                rem_reg, rem_next;
    slot_t                mod_reg, mod_next;
    logic [SLOT_W:0]      trial;

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        div_next  = div_reg;
        rem_next  = rem_reg;
        mod_next  = mod_reg;
        trial     = {rem_reg, div_reg[HASH_W-1]};

        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            div_next  = dividend;
            rem_next  = '0;
            mod_next  = modulus;
        end else if (busy_reg) begin
            // remainder stays below the modulus, so one subtract restores it
            if (trial >= {1'b0, mod_reg}) begin
                rem_next = SLOT_W'(trial - {1'b0, mod_reg});
            end else begin
                rem_next = trial[SLOT_W-1:0];
            end
            div_next = div_reg << 1;
            cnt_next = cnt_reg + REM_CNT_W'(1);
            if (cnt_reg == REM_CNT_W'(HASH_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        div_reg <= div_next;
        rem_reg <= rem_next;
        mod_reg <= mod_next;
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

    a_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        start |-> !busy_reg)
        else $error("remainder unit restarted while busy");

    a_done_after_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> $past(busy_reg) && !busy_reg)
        else $error("done without a finished run");

endmodule

// File: rtl/string_hash_index_engine_top.sv
// String hash index engine. Key bytes stream in one per beat with tlast on the final
// byte. A final byte starts the single shift-subtract remainder unit; the result beat
// (hash and slot index) is loaded into the output register when the remainder is done
// and that register is free. The input is not ready from the final byte until the
// result is loaded; a result that finds the output register still full holds it longer.
// Once loaded, the next key may be taken while the result waits.
// Depends on shie_pkg, shie_byte_unit and shie_mod_unit.
module string_hash_index_engine_top
    import shie_pkg::*;
#(
    parameter int FOLD_CHUNK_BYTES = 3
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // configuration writes
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    // key bytes
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,   // [6:0] key_byte, [7] zero
    input  logic                  s_tlast,   // last_byte
    // results
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [79:0]           m_tdata    // [63:0] hash_value, [79:64] slot_index
);

    localparam int CHUNK_W = 8 * FOLD_CHUNK_BYTES;
    localparam int FILL_W  = $clog2(FOLD_CHUNK_BYTES + 1);

    state_t             state_reg, state_next;
    mode_t              hash_mode_reg;
    slot_t              index_modulus_reg;
    hash_t              hash_reg;
    logic [CHUNK_W-1:0] chunk_reg;
    logic [FILL_W-1:0]  fill_reg;
    logic               at_key_start_reg;
    logic               m_valid_reg;
    hash_t              out_hash_reg;
    slot_t              out_slot_reg;

    hash_t              hash_upd;
    logic [CHUNK_W-1:0] chunk_upd;
    logic [FILL_W-1:0]  fill_upd;
    logic               in_beat;
    logic               mod_start;
    logic               mod_done;
    slot_t              mod_rem;
    logic               out_free;
    logic               out_load;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_IDLE);
    assign in_beat   = s_tvalid && s_tready;
    assign mod_start = in_beat && s_tlast;
    assign out_free  = !m_valid_reg || m_tready;
    assign out_load  = out_free && ((state_reg == ST_MOD && mod_done) || state_reg == ST_HOLD);

    shie_byte_unit #(
        .FOLD_CHUNK_BYTES (FOLD_CHUNK_BYTES)
    ) u_byte (
        .hash_mode    (hash_mode_reg),
        .key_byte     (s_tdata[KEY_W-1:0]),
        .last_byte    (s_tlast),
        .at_key_start (at_key_start_reg),
        .hash_in      (hash_reg),
        .chunk_in     (chunk_reg),
        .fill_in      (fill_reg),
        .hash_out     (hash_upd),
        .chunk_out    (chunk_upd),
        .fill_out     (fill_upd)
    );

    shie_mod_unit u_mod (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (mod_start),
        .dividend  (hash_upd),
        .modulus   (index_modulus_reg),
        .done      (mod_done),
        .remainder (mod_rem)
    );

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (mod_start) begin
                    state_next = ST_MOD;
                end
            end
            ST_MOD: begin
                if (mod_done) begin
                    state_next = out_free ? ST_IDLE : ST_HOLD;
                end
            end
            ST_HOLD: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= ST_IDLE;
            hash_mode_reg     <= HASH_MODE_RST;
            index_modulus_reg <= INDEX_MODULUS_RST;
            hash_reg          <= '0;
            chunk_reg         <= '0;
            fill_reg          <= '0;
            at_key_start_reg  <= 1'b1;
            m_valid_reg       <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_HASH_MODE:     hash_mode_reg     <= cfg_data[MODE_W-1:0];
                    CFG_INDEX_MODULUS: index_modulus_reg <= cfg_data[SLOT_W-1:0];
                    default: ;
                endcase
            end
            if (in_beat) begin
                hash_reg         <= hash_upd;
                chunk_reg        <= chunk_upd;
                fill_reg         <= fill_upd;
                at_key_start_reg <= s_tlast;
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
        // hash_reg holds the finished key until the result is loaded
        if (out_load) begin
            out_hash_reg <= hash_reg;
            out_slot_reg <= (index_modulus_reg == '0) ? '0 : mod_rem;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {out_slot_reg, out_hash_reg};

    a_last_starts_mod: assert property (@(posedge aclk) disable iff (!aresetn)
        mod_start |=> state_reg == ST_MOD)
        else $error("final byte did not start the remainder");

    a_done_only_in_mod: assert property (@(posedge aclk) disable iff (!aresetn)
        mod_done |-> state_reg == ST_MOD)
        else $error("remainder finished outside its state");

    a_key_closed_while_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg != ST_IDLE |-> at_key_start_reg)
        else $error("key still open while reducing");

    a_slot_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_load && index_modulus_reg != '0) |=>
            m_tdata[79:64] < $past(index_modulus_reg))
        else $error("slot index not below the modulus");

endmodule

// File: bench/testbench.sv
`timescale 1ns / 1ps
// Self-checking bench for string_hash_index_engine_top: streams keys in the three hash modes
// and checks every hash/slot beat against an in-bench predictor. Depends on shie_pkg.
module testbench;
    import shie_pkg::*;

    localparam int    FOLD_BYTES  = 3;
    localparam int    DRAIN_WAIT  = 80;     // covers the remainder unit plus output reg
    localparam int    KEY_TARGET  = 1500;
    localparam mode_t MODE_SPARE  = 2'd3;   // unused code, hashes as polynomial

    typedef struct packed {
        logic [KEY_W-1:0] key_byte;
        logic             last_byte;
    } key_beat_t;

    typedef struct {
        hash_t hash;
        slot_t slot;
    } key_result_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [7:0]            s_tdata   = '0;   // [6:0] key_byte, [7] zero
    logic                  s_tlast   = 1'b0; // last_byte
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [79:0]           m_tdata;          // [63:0] hash_value, [79:64] slot_index

    key_beat_t   pending_beats[$];
    key_result_t expected_slots[$];
    int          beats_queued   = 0;
    int          idle_pct       = 26;
    int          error_count    = 0;
    logic        key_beat_taken = 1'b0;

    // predictor state
    mode_t            cur_mode    = HASH_MODE_RST;
    slot_t            cur_modulus = INDEX_MODULUS_RST;
    hash_t            run_hash    = '0;
    logic [23:0]      fold_word   = '0;
    int               fold_fill   = 0;
    logic             key_fresh   = 1'b1;

    string_hash_index_engine_top #(
        .FOLD_CHUNK_BYTES(FOLD_BYTES)
    ) uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    initial begin
        #4_000_000;
        $display("string_hash_index_engine_top regression: fail");
        $finish;
    end

    function automatic logic idle_roll();
        return $urandom_range(0, 99) < idle_pct;
    endfunction

    // Applies one key byte to the predicted hash; on the last byte it queues the hash/slot result.
    task automatic hash_key_byte(input logic [KEY_W-1:0] b, input logic last);
        key_result_t res;
        if (key_fresh) begin
            run_hash  = (cur_mode == MODE_DJB) ? DJB_SEED : '0;
            fold_word = '0;
            fold_fill = 0;
            key_fresh = 1'b0;
        end
        case (cur_mode)
            MODE_FOLD: begin
                fold_word = {fold_word[15:0], 1'b0, b};
                fold_fill++;
                // full chunk, or a partial chunk closed by the last byte
                if (fold_fill >= FOLD_BYTES || last) begin
                    run_hash  = run_hash ^ {40'd0, fold_word};
                    fold_word = '0;
                    fold_fill = 0;
                end
            end
            MODE_DJB: run_hash = run_hash * 64'd33 + {57'd0, b};
            default:  run_hash = run_hash * 64'd31 + {57'd0, b};
        endcase
        if (last) begin
            res.hash = run_hash;
            res.slot = (cur_modulus == '0) ? '0 : slot_t'(run_hash % hash_t'(cur_modulus));
            expected_slots.push_back(res);
            key_fresh = 1'b1;
        end
    endtask

    task automatic flag_error(input string what, input hash_t exp_h, input slot_t exp_s,
                              input hash_t got_h, input slot_t got_s);
        error_count++;
        if (error_count <= 10)
            $display("%0t %s: expected hash %h slot %0d, got hash %h slot %0d",
                     $time, what, exp_h, exp_s, got_h, got_s);
    endtask

    // monitor: register writes, accepted key beats and result beats
    always @(posedge aclk) begin
        key_result_t want;
        key_beat_taken <= s_tvalid && s_tready;
        if (aresetn) begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_HASH_MODE:     cur_mode    = mode_t'(cfg_data);
                    CFG_INDEX_MODULUS: cur_modulus = cfg_data;
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready) begin
                if (expected_slots.size() == 0) begin
                    flag_error("unexpected result", '0, '0, m_tdata[63:0], m_tdata[79:64]);
                end else begin
                    want = expected_slots.pop_front();
                    if (want.hash !== m_tdata[63:0] || want.slot !== m_tdata[79:64])
                        flag_error("result mismatch", want.hash, want.slot,
                                   m_tdata[63:0], m_tdata[79:64]);
                end
            end
            if (s_tvalid && s_tready)
                hash_key_byte(s_tdata[KEY_W-1:0], s_tlast);
        end
    end

    // key beat driver
    always @(negedge aclk) begin
        key_beat_t nxt;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (s_tvalid && !key_beat_taken) begin
            // hold the beat until it is taken
        end else if (pending_beats.size() != 0 && !idle_roll()) begin
            nxt = pending_beats.pop_front();
            s_tdata  <= {1'b0, nxt.key_byte};
            s_tlast  <= nxt.last_byte;
            s_tvalid <= 1'b1;
        end else begin
            s_tvalid <= 1'b0;
        end
    end

    always @(negedge aclk) begin
        m_tready <= aresetn && !idle_roll();
    end

    task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic add_beat(input logic [KEY_W-1:0] b, input logic last);
        key_beat_t kb;
        kb.key_byte  = b;
        kb.last_byte = last;
        pending_beats.push_back(kb);
        beats_queued++;
    endtask

    function automatic logic [KEY_W-1:0] random_char();
        case ($urandom_range(0, 15))
            0:       return '0;
            1:       return '1;
            default: return KEY_W'($urandom_range(1, 127));
        endcase
    endfunction

    task automatic add_key(input int len);
        for (int i = 0; i < len; i++)
            add_beat(random_char(), i == len - 1);
    endtask

    // wait until every beat is in and every result out, then let the remainder unit settle
    task automatic drain();
        do @(posedge aclk);
        while (pending_beats.size() != 0 || s_tvalid || expected_slots.size() != 0);
        repeat (DRAIN_WAIT) @(posedge aclk);
    endtask

    initial begin
        int    phase;
        int    n_keys;
        mode_t mode_pick;
        slot_t mod_pick;

        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // reset settings: polynomial, table of 100
        add_beat(7'd127, 1'b1);
        add_beat(7'd0, 1'b0);
        add_beat(7'd1, 1'b0);
        add_beat(7'd64, 1'b0);
        add_beat(7'd127, 1'b1);
        drain();

        write_reg(CFG_HASH_MODE, 16'(MODE_FOLD));
        write_reg(CFG_INDEX_MODULUS, 16'hFFFF);
        add_beat(7'h61, 1'b0);
        add_beat(7'h62, 1'b0);
        add_beat(7'h63, 1'b1);
        repeat (3) add_beat(7'd127, 1'b0);
        add_beat(7'd127, 1'b1);     // one-byte tail chunk
        for (int i = 1; i <= 5; i++)
            add_beat(KEY_W'(i), i == 5);   // two-byte tail chunk
        drain();

        write_reg(CFG_HASH_MODE, 16'(MODE_DJB));
        write_reg(CFG_INDEX_MODULUS, 16'd1);
        add_beat(7'h78, 1'b1);
        add_beat(7'd0, 1'b0);
        add_beat(7'd127, 1'b1);
        drain();

        write_reg(CFG_HASH_MODE, 16'(MODE_SPARE));
        write_reg(CFG_INDEX_MODULUS, 16'd0);
        add_beat(7'd85, 1'b0);
        add_beat(7'd42, 1'b1);
        drain();

        // mode switched mid-key: pending fold chunk is dropped when the last byte is polynomial
        write_reg(CFG_HASH_MODE, 16'(MODE_FOLD));
        write_reg(CFG_INDEX_MODULUS, 16'd7);
        add_beat(7'd100, 1'b0);
        add_beat(7'd101, 1'b0);
        drain();
        write_reg(CFG_HASH_MODE, 16'(MODE_POLY));
        add_beat(7'd102, 1'b1);
        drain();

        phase = 0;
        while (beats_queued < KEY_TARGET) begin
            phase++;
            idle_pct = (phase == 3) ? 0 : 26;
            mode_pick = ($urandom_range(0, 9) == 0) ? MODE_SPARE : mode_t'($urandom_range(0, 2));
            case ($urandom_range(0, 11))
                0:       mod_pick = '0;
                1:       mod_pick = 16'd1;
                2:       mod_pick = 16'hFFFF;
                3, 4:    mod_pick = slot_t'($urandom_range(2, 64));
                default: mod_pick = slot_t'($urandom_range(1, 65535));
            endcase
            // upper data bits of the mode write are don't-care
            write_reg(CFG_HASH_MODE, {14'($urandom_range(0, 16383)), mode_pick});
            write_reg(CFG_INDEX_MODULUS, mod_pick);
            n_keys = $urandom_range(25, 40);
            for (int k = 0; k < n_keys; k++)
                add_key(($urandom_range(0, 9) == 0) ? $urandom_range(13, 40)
                                                    : $urandom_range(1, 12));
            // sometimes leave a key open across the next register change
            if ($urandom_range(0, 3) == 0) begin
                repeat ($urandom_range(1, 5)) add_beat(random_char(), 1'b0);
            end
            drain();
        end
        idle_pct = 26;
        add_key($urandom_range(1, 4));
        drain();

        @(negedge aclk);
        error_count += expected_slots.size();
        if (error_count == 0)
            $display("string_hash_index_engine_top regression: pass");
        else
            $display("string_hash_index_engine_top regression: fail");
        $finish;
    end

endmodule

// File: files.f
rtl/shie_pkg.sv
rtl/shie_byte_unit.sv
rtl/shie_mod_unit.sv
rtl/string_hash_index_engine_top.sv
bench/testbench.sv
